// ===== design/eavt_pkg.sv =====
// Package for the epoch-aged value tag table: request and result structs,
// queue command type, operation and outcome codes, tag layout constants.
// No dependencies.
package eavt_pkg;

  typedef struct packed {
    logic [2:0]  operation;
    logic [23:0] address;
    logic [15:0] word_value;
    logic        pack_art;
    logic [11:0] ram_page;
    logic [7:0]  epoch_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        has_content;
    logic        repl_art;
    logic [19:0] word_index;
    logic        stored;
    logic        was_live;
    logic [7:0]  epoch_now;
  } out_t;

  localparam logic [2:0] OP_STORE   = 3'd0;
  localparam logic [2:0] OP_LOOKUP  = 3'd1;
  localparam logic [2:0] OP_TICK    = 3'd2;
  localparam logic [2:0] OP_RESTAMP = 3'd3;
  localparam logic [2:0] OP_SET_EP  = 3'd4;
  localparam logic [2:0] OP_INVAL   = 3'd5;

  localparam logic [1:0] OC_HIT      = 2'd0;
  localparam logic [1:0] OC_VAL_MISS = 2'd1;
  localparam logic [1:0] OC_EP_MISS  = 2'd2;
  localparam logic [1:0] OC_NO_PAGE  = 2'd3;

  localparam logic CFG_HIRES = 1'b0;
  localparam logic CFG_MAXP  = 1'b1;

  // Tag word: value, valid, epoch, pack-art flag.
  localparam int TAG_W        = 26;
  localparam int TAG_VALID_B  = 16;
  localparam int TAG_EP_LO    = 17;
  localparam int TAG_REPL_B   = 25;
  localparam int WORD_W       = 12;   // words per page: 4096
  localparam int EPOCH_WINDOW = 16;

  typedef enum logic [2:0] {
    K_NOP,
    K_STORE,
    K_ALLOC_STORE,
    K_LOOKUP,
    K_CLEAR_ALL,
    K_RESTAMP
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    out_t        res;    // result fields known up front
    logic [7:0]  page;
    logic        half;   // restamp: upper half of the page
    logic [15:0] value;
    logic        pack;
  } cmd_t;

endpackage

// ===== design/eavt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eavt_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 1048576
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

// ===== design/eavt_queue.sv =====
// Two-entry command queue between the front and the back end.
// Depends on eavt_pkg for the command type.
module eavt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  eavt_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output eavt_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import eavt_pkg::*;

  cmd_t       slot_q [2];
  logic       rd_ptr_q, wr_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = slot_q[rd_ptr_q];
  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
endmodule

// ===== design/eavt_front.sv =====
// Front end: accepts requests, holds configuration, epoch and page
// allocation state, and turns each request into a queue command.
// Depends on eavt_pkg.
module eavt_front #(
  parameter int PAGES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [8:0]    cfg_data_i,
  input  logic          push_i,
  input  eavt_pkg::in_t in_data_i,
  output eavt_pkg::cmd_t cmd_o,
  output logic [PAGES-1:0] present_o
);
  import eavt_pkg::*;

  localparam int PG_W = (PAGES > 1) ? $clog2(PAGES) : 1;

  logic             hires_q;
  logic [8:0]       max_pages_q;
  logic [8:0]       used_q, used_d;
  logic             stopped_q, stopped_d;
  logic [7:0]       epoch_q, epoch_d;
  logic [PAGES-1:0] present_q, present_d;

  logic        addr_ok, pg_in, pg_here, rp_in, rp_here;
  logic [19:0] idx;
  logic [10:0] rp;
  cmd_t        cmd;

  always_comb begin
    addr_ok = ~in_data_i.address[23];
    idx     = in_data_i.address[20:1];
    rp      = in_data_i.ram_page[11:1];
    pg_in   = (32'(idx[19:12]) < PAGES);
    pg_here = pg_in && present_q[idx[12+PG_W-1:12]];
    rp_in   = (32'(rp) < PAGES);
    rp_here = rp_in && present_q[rp[PG_W-1:0]];

    used_d    = used_q;
    stopped_d = stopped_q;
    epoch_d   = epoch_q;
    present_d = present_q;

    cmd       = '0;
    cmd.kind  = K_NOP;
    cmd.page  = idx[19:12];
    cmd.value = in_data_i.word_value;
    cmd.pack  = in_data_i.pack_art;

    case (in_data_i.operation)
      OP_STORE: begin
        if (addr_ok) begin
          cmd.res.word_index = idx;
        end
        if (hires_q && addr_ok) begin
          if (pg_here) begin
            cmd.kind       = K_STORE;
            cmd.res.stored = 1'b1;
          end else if (pg_in && !stopped_q) begin
            if (({1'b0, used_q} + 10'd1) > {1'b0, max_pages_q}) begin
              stopped_d = 1'b1;
            end else begin
              cmd.kind       = K_ALLOC_STORE;
              cmd.res.stored = 1'b1;
              used_d         = used_q + 9'd1;
              present_d[idx[12+PG_W-1:12]] = 1'b1;
            end
          end
        end
      end
      OP_LOOKUP: begin
        if (addr_ok && pg_here) begin
          cmd.kind           = K_LOOKUP;
          cmd.res.word_index = idx;
        end else begin
          cmd.res.outcome = OC_NO_PAGE;
        end
      end
      OP_TICK: begin
        epoch_d = epoch_q + 8'd1;
        if (epoch_d == 8'd0 && hires_q) begin
          cmd.kind = K_CLEAR_ALL;
        end
      end
      OP_RESTAMP: begin
        if (hires_q && rp_here) begin
          cmd.kind = K_RESTAMP;
          cmd.page = 8'(rp);
          cmd.half = in_data_i.ram_page[0];
        end
      end
      OP_SET_EP: epoch_d = in_data_i.epoch_in;
      OP_INVAL:  cmd.kind = K_CLEAR_ALL;
      default:   ;
    endcase
    cmd.res.epoch_now = epoch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hires_q     <= 1'b0;
      max_pages_q <= 9'd256;
      used_q      <= '0;
      stopped_q   <= 1'b0;
      epoch_q     <= '0;
      present_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HIRES: hires_q     <= cfg_data_i[0];
          CFG_MAXP:  max_pages_q <= cfg_data_i;
          default:   ;
        endcase
      end
      if (push_i) begin
        used_q    <= used_d;
        stopped_q <= stopped_d;
        epoch_q   <= epoch_d;
        present_q <= present_d;
      end
    end
  end

  assign cmd_o     = cmd;
  assign present_o = present_q;
endmodule

// ===== design/eavt_back.sv =====
// Back end: executes queue commands against the tag RAM (read-modify-write,
// page clears, restamp sweeps) and holds the result register.
// Depends on eavt_pkg and eavt_ram.
module eavt_back #(
  parameter int PAGES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  eavt_pkg::cmd_t   head_i,
  input  logic             empty_i,
  input  logic [PAGES-1:0] present_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output eavt_pkg::out_t   out_data_o
);
  import eavt_pkg::*;

  localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W = $clog2(PAGES) + WORD_W;

  typedef enum logic [2:0] {
    B_IDLE, B_CLR, B_STRD, B_EVAL, B_RS_RD, B_RS_WR
  } state_e;

  state_e            state_q;
  cmd_t              cur_q;
  logic [PG_W-1:0]   pg_q;
  logic [WORD_W-1:0] w_q;
  logic              all_q;
  logic              out_valid_q;
  out_t              out_q;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [TAG_W-1:0]  wr_data, rd_data;
  logic [ADDR_W-1:0] cur_addr, head_addr, sweep_addr, rs_addr;
  logic              match, in_win;
  logic [7:0]        age;
  out_t              eval_res;

  eavt_ram #(.WIDTH(TAG_W), .DEPTH(PAGES * (2 ** WORD_W))) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    head_addr  = ADDR_W'({head_i.page, head_i.res.word_index[WORD_W-1:0]});
    cur_addr   = ADDR_W'({cur_q.page, cur_q.res.word_index[WORD_W-1:0]});
    sweep_addr = ADDR_W'({pg_q, w_q});
    rs_addr    = ADDR_W'({cur_q.page, cur_q.half, w_q[WORD_W-2:0]});
    match   = rd_data[TAG_VALID_B:0] == {1'b1, cur_q.value};
    age     = cur_q.res.epoch_now - rd_data[TAG_EP_LO+7:TAG_EP_LO];
    in_win  = (32'(age) < EPOCH_WINDOW);

    // Result of a lookup or store once its tag has been read.
    eval_res = cur_q.res;
    if (cur_q.kind == K_LOOKUP) begin
      if (!match) begin
        eval_res.outcome = OC_VAL_MISS;
      end else begin
        eval_res.repl_art = rd_data[TAG_REPL_B];
        if (in_win) begin
          eval_res.outcome     = OC_HIT;
          eval_res.has_content = 1'b1;
        end else begin
          eval_res.outcome     = OC_EP_MISS;
          eval_res.has_content = rd_data[TAG_REPL_B];
        end
      end
    end else begin
      eval_res.was_live = cur_q.pack && match && in_win;
    end

    pop_o   = (state_q == B_IDLE) && !empty_i && !out_valid_q;
    rd_en   = 1'b0;
    rd_addr = cur_addr;
    wr_en   = 1'b0;
    wr_addr = sweep_addr;
    wr_data = '0;
    case (state_q)
      B_IDLE: begin
        if (pop_o && (head_i.kind == K_STORE || head_i.kind == K_LOOKUP)) begin
          rd_en   = 1'b1;
          rd_addr = head_addr;
        end
      end
      B_CLR:  wr_en = !(all_q && !present_i[pg_q]);
      B_STRD: rd_en = 1'b1;
      B_EVAL: begin
        if (cur_q.kind != K_LOOKUP) begin
          wr_en   = 1'b1;
          wr_addr = cur_addr;
          wr_data = {cur_q.pack, cur_q.res.epoch_now, 1'b1, cur_q.value};
        end
      end
      B_RS_RD: begin
        rd_en   = 1'b1;
        rd_addr = rs_addr;
      end
      B_RS_WR: begin
        wr_en   = rd_data[TAG_VALID_B];
        wr_addr = rs_addr;
        wr_data = {rd_data[TAG_REPL_B], cur_q.res.epoch_now, rd_data[TAG_VALID_B:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      pg_q        <= '0;
      w_q         <= '0;
      all_q       <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            cur_q <= head_i;
            w_q   <= '0;
            case (head_i.kind)
              K_STORE, K_LOOKUP: state_q <= B_EVAL;
              K_ALLOC_STORE: begin
                pg_q    <= head_i.page[PG_W-1:0];
                all_q   <= 1'b0;
                state_q <= B_CLR;
              end
              K_CLEAR_ALL: begin
                pg_q    <= '0;
                all_q   <= 1'b1;
                state_q <= B_CLR;
              end
              K_RESTAMP: state_q <= B_RS_RD;
              default: begin
                out_q       <= head_i.res;
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        B_CLR: begin
          if (all_q && !present_i[pg_q]) begin
            w_q <= '0;
            if (pg_q == PG_W'(PAGES - 1)) begin
              out_q       <= cur_q.res;
              out_valid_q <= 1'b1;
              state_q     <= B_IDLE;
            end else begin
              pg_q <= pg_q + PG_W'(1);
            end
          end else begin
            w_q <= w_q + WORD_W'(1);
            if (&w_q) begin
              if (!all_q) begin
                state_q <= B_STRD;
              end else if (pg_q == PG_W'(PAGES - 1)) begin
                out_q       <= cur_q.res;
                out_valid_q <= 1'b1;
                state_q     <= B_IDLE;
              end else begin
                pg_q <= pg_q + PG_W'(1);
              end
            end
          end
        end
        B_STRD: state_q <= B_EVAL;
        B_EVAL: begin
          out_q       <= eval_res;
          out_valid_q <= 1'b1;
          state_q     <= B_IDLE;
        end
        B_RS_RD: state_q <= B_RS_WR;
        B_RS_WR: begin
          w_q <= w_q + WORD_W'(1);
          if (&w_q[WORD_W-2:0]) begin
            out_q       <= cur_q.res;
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end else begin
            state_q <= B_RS_RD;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

// ===== design/epoch_aged_value_tag_table.sv =====
// Top level of the epoch-aged value tag table: front end, command queue
// and back end with the tag RAM. Depends on eavt_pkg and all eavt_ modules.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+---------------------
//   in      | input     | in_valid_i/in_stall_o | eavt_pkg::in_t
//   out     | output    | out_valid_o/out_stall_i | eavt_pkg::out_t
//   cfg     | input     | cfg_we_i, no wait     | cfg_idx_i, cfg_data_i
//
// A request that needs no tag access takes its result from the command; a
// lookup or store first reads its tag, and a store then writes it back.
// A store that allocates a page first clears its 4096 words, one per
// cycle. A clear of all tags sweeps every present page at one word per
// cycle and skips absent pages; a restamp reads each of the 2048 words of
// a half page and rewrites the valid ones. Reset clears control state
// only; tag contents are cleared when a page is allocated, so no clearing
// pass runs. The front takes requests while the two-entry queue has room.
module epoch_aged_value_tag_table #(
  parameter int PAGES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  eavt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output eavt_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [8:0]     cfg_data_i
);
  import eavt_pkg::*;

  cmd_t             push_cmd, head;
  logic             push, pop, full, empty;
  logic [PAGES-1:0] present;

  // A request is taken whenever the queue has a free slot.
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  eavt_front #(.PAGES(PAGES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .cmd_o      (push_cmd),
    .present_o  (present)
  );

  eavt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  // The back end reads the live page map; pages are only ever added, and a
  // page added behind a queued clear is cleared again before its store.
  eavt_back #(.PAGES(PAGES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .present_i   (present),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );
endmodule

// ===== tb/eavt_tag_checker.sv =====
`timescale 1ns / 100ps
// Checker for the epoch-aged value tag table: watches the request, result
// and register ports, predicts every result and compares it. Needs eavt_pkg.
module eavt_tag_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  eavt_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  eavt_pkg::out_t out_data_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [8:0]     cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import eavt_pkg::*;

  // Shadow of the tag table. Only words of present pages are ever written,
  // and pages are never released, so clearing all tags empties the map.
  logic [25:0]   tag_mem [int unsigned];
  bit   [255:0]  page_live;
  int unsigned   pages_taken;
  bit            alloc_off;
  logic [7:0]    frame_ep;
  bit            hires_on;
  logic [8:0]    page_cap;
  out_t          exp_results[$];

  function automatic bit fresh(logic [25:0] tag);
    logic [7:0] age;
    age = frame_ep - tag[24:17];
    return age < EPOCH_WINDOW;
  endfunction

  function automatic bit claim_page(int unsigned pg);
    if (page_live[pg]) return 1'b1;
    if (alloc_off) return 1'b0;
    if (pages_taken + 1 > page_cap) begin
      alloc_off = 1'b1;
      return 1'b0;
    end
    page_live[pg] = 1'b1;
    pages_taken++;
    return 1'b1;
  endfunction

  function automatic out_t predict_tag_access(in_t rq);
    out_t        r;
    int unsigned idx, pg, base, w0;
    logic [25:0] prev, tag;
    bit          addr_ok;
    r = '0;
    idx = rq.address[20:1];
    pg = idx >> 12;
    addr_ok = rq.address < 24'h800000;
    case (rq.operation)
      OP_STORE: begin
        if (addr_ok) r.word_index = 20'(idx);
        if (hires_on && addr_ok && claim_page(pg)) begin
          prev = tag_mem.exists(idx) ? tag_mem[idx] : '0;
          tag = {1'b0, frame_ep, 1'b1, rq.word_value};
          if (rq.pack_art) begin
            r.was_live = prev[16:0] == {1'b1, rq.word_value} && fresh(prev);
            tag[25] = 1'b1;
          end
          tag_mem[idx] = tag;
          r.stored = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (!addr_ok || !page_live[pg]) begin
          r.outcome = OC_NO_PAGE;
        end else begin
          tag = tag_mem.exists(idx) ? tag_mem[idx] : '0;
          r.word_index = 20'(idx);
          if (tag[16:0] != {1'b1, rq.word_value}) begin
            r.outcome = OC_VAL_MISS;
          end else begin
            r.repl_art = tag[25];
            if (fresh(tag)) begin
              r.outcome = OC_HIT;
              r.has_content = 1'b1;
            end else begin
              r.outcome = OC_EP_MISS;
              r.has_content = tag[25];
            end
          end
        end
      end
      OP_TICK: begin
        frame_ep = frame_ep + 8'd1;
        if (frame_ep == 8'd0 && hires_on) tag_mem.delete();
      end
      OP_RESTAMP: begin
        // Half a page of 2048 words; page numbers beyond the table are absent.
        pg = rq.ram_page >> 1;
        if (hires_on && pg < 256 && page_live[pg]) begin
          base = pg << 12;
          w0 = rq.ram_page[0] ? 2048 : 0;
          for (int w = w0; w < w0 + 2048; w++) begin
            if (tag_mem.exists(base + w) && tag_mem[base + w][16]) begin
              tag_mem[base + w][24:17] = frame_ep;
            end
          end
        end
      end
      OP_SET_EP: frame_ep = rq.epoch_in;
      OP_INVAL: tag_mem.delete();
      default: ;
    endcase
    r.epoch_now = frame_ep;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t ex;
    if (!rst_ni) begin
      tag_mem.delete();
      page_live = '0;
      pages_taken = 0;
      alloc_off = 1'b0;
      frame_ep = '0;
      hires_on = 1'b0;
      page_cap = 9'd256;
      exp_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HIRES) hires_on = cfg_data_i[0];
        else page_cap = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) exp_results.push_back(predict_tag_access(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (exp_results.size() == 0) begin
          $error("result arrived with nothing expected");
          fail_count_o++;
        end else begin
          ex = exp_results.pop_front();
          if (ex.outcome != out_data_i.outcome) begin
            $error("outcome: expected %0d, got %0d", ex.outcome, out_data_i.outcome);
            fail_count_o++;
          end
          if (ex.has_content != out_data_i.has_content) begin
            $error("has_content: expected %0d, got %0d", ex.has_content,
                   out_data_i.has_content);
            fail_count_o++;
          end
          if (ex.repl_art != out_data_i.repl_art) begin
            $error("repl_art: expected %0d, got %0d", ex.repl_art, out_data_i.repl_art);
            fail_count_o++;
          end
          if (ex.word_index != out_data_i.word_index) begin
            $error("word_index: expected %h, got %h", ex.word_index, out_data_i.word_index);
            fail_count_o++;
          end
          if (ex.stored != out_data_i.stored) begin
            $error("stored: expected %0d, got %0d", ex.stored, out_data_i.stored);
            fail_count_o++;
          end
          if (ex.was_live != out_data_i.was_live) begin
            $error("was_live: expected %0d, got %0d", ex.was_live, out_data_i.was_live);
            fail_count_o++;
          end
          if (ex.epoch_now != out_data_i.epoch_now) begin
            $error("epoch_now: expected %0d, got %0d", ex.epoch_now, out_data_i.epoch_now);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = exp_results.size();
  end

endmodule

// ===== tb/epoch_aged_value_tag_table_test.sv =====
`timescale 1ns / 100ps
// Top of the tag table testbench: clock, reset, request stimulus, register
// phases and verdict. Needs eavt_pkg, the table RTL and eavt_tag_checker.
module epoch_aged_value_tag_table_test;
  import eavt_pkg::*;

  // The two spare operation codes, which must leave everything untouched.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  // Generous bound: page clears, restamps and stalls included, several times over.
  localparam int CYCLE_LIMIT = 4000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_idx = CFG_HIRES;
  logic [8:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         cycles = 0;
  bit         idling = 1'b1;
  int         op_seen [8];

  // A handful of pages keeps the cost of page clears and clear sweeps down.
  logic [7:0]  page_pool [6] = '{8'd0, 8'd1, 8'd37, 8'd128, 8'd200, 8'd255};
  // Recent stores, so that many lookups and pack stores find a matching tag.
  logic [23:0] recent_addr [16];
  logic [15:0] recent_val [16];

  always #5 clk_i = ~clk_i;

  epoch_aged_value_tag_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  eavt_tag_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // The result side stalls at random, except during the quiet stretch.
  always @(posedge clk_i) begin
    out_stall <= idling && $urandom_range(99) < 32;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_t mk(logic [2:0] op, logic [23:0] addr, logic [15:0] val,
                             logic pack, logic [11:0] rpage, logic [7:0] ein);
    in_t r;
    r.operation = op;
    r.address = addr;
    r.word_value = val;
    r.pack_art = pack;
    r.ram_page = rpage;
    r.epoch_in = ein;
    return r;
  endfunction

  // Byte address inside one of the pool pages, or in any page; bits 22
  // and 21 alias and bit 23 puts the address out of range now and then.
  function automatic logic [23:0] pick_addr(bit any_page);
    logic [7:0] pg;
    pg = any_page ? 8'($urandom_range(255)) : page_pool[$urandom_range(5)];
    return {1'($urandom_range(99) < 3), 2'($urandom), pg, 12'($urandom), 1'($urandom)};
  endfunction

  function automatic in_t random_request(bit any_page);
    in_t         r;
    int          roll, k;
    roll = $urandom_range(999);
    k = $urandom_range(15);
    r = mk(OP_LOOKUP, pick_addr(any_page), 16'($urandom), 1'($urandom),
           12'($urandom), 8'($urandom));
    if (roll < 380) begin
      r.operation = OP_STORE;
      if ($urandom_range(3) == 0) begin
        // Restore a recent word, so a pack store may find a live entry.
        r.address = recent_addr[k];
        r.word_value = recent_val[k];
      end
    end else if (roll < 800) begin
      if ($urandom_range(9) < 6) begin
        r.address = recent_addr[k] ^ {1'b0, 2'($urandom), 21'd0};
        r.word_value = recent_val[k];
      end
    end else if (roll < 860) begin
      r.operation = OP_TICK;
    end else if (roll < 890) begin
      r.operation = OP_RESTAMP;
      if ($urandom_range(3) != 0) r.ram_page = {3'($urandom), page_pool[$urandom_range(5)],
                                                1'($urandom)} & 12'h1FF;
    end else if (roll < 930) begin
      r.operation = OP_SET_EP;
      if ($urandom_range(1) == 0) r.epoch_in = 8'($urandom_range(240, 255));
    end else if (roll < 934) begin
      r.operation = OP_INVAL;
    end else if (roll < 950) begin
      r.operation = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
    end
    return r;
  endfunction

  // Offers one request and returns once it has been taken. Stall is checked
  // at the falling edge, when it is settled for the coming rising edge.
  task automatic send(in_t r);
    int k;
    if (idling && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= r;
    forever begin
      @(negedge clk_i);
      if (!in_stall) break;
    end
    @(posedge clk_i);
    op_seen[r.operation]++;
    if (r.operation == OP_STORE) begin
      k = $urandom_range(15);
      recent_addr[k] = r.address;
      recent_val[k] = r.word_value;
    end
  endtask

  // Lets the table drain: every expected result in, then a few spare cycles.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Registers are only written while the table is idle.
  task automatic set_regs(logic hires, logic [8:0] cap);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_HIRES;
    cfg_data <= {8'd0, hires};
    @(posedge clk_i);
    cfg_idx <= CFG_MAXP;
    cfg_data <= cap;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int count, bit any_page);
    for (int i = 0; i < count; i++) begin
      // A long quiet stretch with no idling on either side.
      idling = !(i >= count / 3 && i < count / 2);
      // Once in the phase, hold off until the table has caught up.
      if (i == count / 4) drain();
      send(random_request(any_page));
    end
    idling = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      recent_addr[i] = pick_addr(1'b0) & 24'h7FFFFF;
      recent_val[i] = 16'($urandom);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Disabled: stores and restamps do nothing, lookups find no page.
    set_regs(1'b0, 9'd256);
    send(mk(OP_STORE, 24'h000000, 16'h1234, 1'b0, 12'h000, 8'h00));
    send(mk(OP_LOOKUP, 24'h000000, 16'h1234, 1'b0, 12'h000, 8'h00));
    send(mk(OP_RESTAMP, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'h00));
    send(mk(OP_TICK, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'h00));

    // Enabled with the full page budget: hits, misses, pack art, ageing.
    set_regs(1'b1, 9'd256);
    send(mk(OP_STORE, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'h00));
    send(mk(OP_LOOKUP, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'h00));
    send(mk(OP_LOOKUP, 24'h000000, 16'hFFFF, 1'b0, 12'h000, 8'h00));
    send(mk(OP_STORE, 24'h7FFFFF, 16'hFFFF, 1'b1, 12'h000, 8'h00));
    send(mk(OP_STORE, 24'h7FFFFE, 16'hFFFF, 1'b1, 12'h000, 8'h00));
    send(mk(OP_STORE, 24'hFFFFFF, 16'hABCD, 1'b0, 12'h000, 8'h00));
    send(mk(OP_LOOKUP, 24'hFFFFFF, 16'hFFFF, 1'b0, 12'h000, 8'h00));
    // Far beyond the age window: the pack-art word still has content.
    send(mk(OP_SET_EP, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'hFF));
    send(mk(OP_LOOKUP, 24'h7FFFFF, 16'hFFFF, 1'b0, 12'h000, 8'h00));
    send(mk(OP_LOOKUP, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'h00));
    // Restamp brings page 0 back into the window; an out-of-range page is ignored.
    send(mk(OP_RESTAMP, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'h00));
    send(mk(OP_RESTAMP, 24'h000000, 16'h0000, 1'b0, 12'hFFF, 8'h00));
    send(mk(OP_LOOKUP, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'h00));
    // Epoch wrap clears every tag.
    send(mk(OP_TICK, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'h00));
    send(mk(OP_LOOKUP, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'h00));
    send(mk(OP_STORE, 24'h012346, 16'h5A5A, 1'b1, 12'h000, 8'h00));
    send(mk(OP_INVAL, 24'h000000, 16'h0000, 1'b0, 12'h000, 8'h00));
    send(mk(OP_LOOKUP, 24'h012346, 16'h5A5A, 1'b0, 12'h000, 8'h00));
    send(mk(OP_SPARE6, 24'h7FFFFF, 16'hFFFF, 1'b1, 12'hFFF, 8'hFF));
    send(mk(OP_SPARE7, 24'h7FFFFF, 16'hFFFF, 1'b1, 12'hFFF, 8'hFF));

    random_phase(900, 1'b0);
    // No budget left: the first store into a new page stops allocation for good.
    set_regs(1'b1, 9'd0);
    random_phase(200, 1'b1);
    set_regs(1'b0, 9'd256);
    random_phase(150, 1'b1);

    drain();
    $display("Sent %0d stores, %0d lookups, %0d ticks, %0d restamps, %0d epoch sets,",
             op_seen[OP_STORE], op_seen[OP_LOOKUP], op_seen[OP_TICK],
             op_seen[OP_RESTAMP], op_seen[OP_SET_EP]);
    $display("%0d clears and %0d spare codes over four register settings.",
             op_seen[OP_INVAL], op_seen[OP_SPARE6] + op_seen[OP_SPARE7]);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/eavt_pkg.sv
design/eavt_ram.sv
design/eavt_queue.sv
design/eavt_front.sv
design/eavt_back.sv
design/epoch_aged_value_tag_table.sv
tb/eavt_tag_checker.sv
tb/epoch_aged_value_tag_table_test.sv
